/* design/i2cmbw_pkg.sv */
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// i2cmbw_pkg
// Shared types and constants for the write-only i2c byte master.
// ----------------------------------------------------------------------------
package i2cmbw_pkg;

	localparam int unsigned TICK_W = 16;

	localparam logic [7:0]        BYTE_MSB      = 8'h80;
	localparam logic [3:0]        BITS_PER_BYTE = 4'd8;
	localparam logic [TICK_W-1:0] TICKS_RESET   = 16'd2;

	// command codes of an input word
	typedef enum logic {
		CMD_TICK    = 1'b0,
		CMD_REQUEST = 1'b1
	} cmd_t;

	// pin phases of one byte sequence
	typedef enum logic [3:0] {
		PH_IDLE       = 4'd0,
		PH_ST_SDA_HI  = 4'd1,
		PH_ST_SCL_HI  = 4'd2,
		PH_ST_SDA_LO  = 4'd3,
		PH_ST_SCL_LO  = 4'd4,
		PH_BIT_SET    = 4'd5,
		PH_BIT_SCL_HI = 4'd6,
		PH_BIT_SCL_LO = 4'd7,
		PH_ACK_REL    = 4'd8,
		PH_ACK_SCL_HI = 4'd9,
		PH_ACK_SAMPLE = 4'd10,
		PH_ACK_SCL_LO = 4'd11,
		PH_SP_SCL_LO  = 4'd12,
		PH_SP_SDA_LO  = 4'd13,
		PH_SP_SCL_HI  = 4'd14,
		PH_SP_SDA_HI  = 4'd15
	} phase_t;

	// sequencer state
	typedef struct packed {
		phase_t             step;
		logic [TICK_W-1:0]  hold;
		logic [7:0]         shift;
		logic [3:0]         bits;
		logic               stop;
		logic               scl;
		logic               sda;
	} seq_state_t;

	// result flags of one word
	typedef struct packed {
		logic busy;
		logic ack_valid;
		logic nack;
		logic rejected;
	} seq_flags_t;

endpackage
`default_nettype wire

/* design/i2cmbw_step.sv */
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// i2cmbw_step
// Next-state logic of the phase sequencer for one input word.
// ----------------------------------------------------------------------------
module i2cmbw_step
	import i2cmbw_pkg::*;
(
	input  wire seq_state_t        cur,
	input  wire [TICK_W-1:0]       phase_ticks,
	input  wire                    command,
	input  wire [7:0]              data_byte,
	input  wire                    frame_start,
	input  wire                    frame_end,
	input  wire                    sda_in,
	output seq_state_t             nxt,
	output seq_flags_t             flags
);

	logic [TICK_W-1:0] hold_load;
	logic [TICK_W-1:0] hold_dec;
	logic              busy;
	logic              do_enter;
	logic              reject;
	phase_t            enter_step;
	seq_state_t        base;

	// zero hold is treated as one tick
	assign hold_load = (phase_ticks == '0) ? {{(TICK_W-1){1'b0}}, 1'b1} : phase_ticks;
	assign hold_dec  = (cur.hold == '0) ? cur.hold : cur.hold - {{(TICK_W-1){1'b0}}, 1'b1};
	assign busy      = (cur.step != PH_IDLE);

	// pick the phase to enter, if any
	always_comb begin
		base       = cur;
		do_enter   = 1'b0;
		enter_step = PH_IDLE;
		reject     = 1'b0;
		if (cmd_t'(command) == CMD_REQUEST) begin
			if (busy) begin
				reject = 1'b1;
			end else begin
				base.shift = data_byte;
				base.bits  = 4'd0;
				base.stop  = frame_end;
				do_enter   = 1'b1;
				enter_step = frame_start ? PH_ST_SDA_HI : PH_BIT_SET;
			end
		end else if (busy) begin
			base.hold = hold_dec;
			if (hold_dec == '0) begin
				do_enter = 1'b1;
				case (cur.step)
					PH_ST_SDA_HI:  enter_step = PH_ST_SCL_HI;
					PH_ST_SCL_HI:  enter_step = PH_ST_SDA_LO;
					PH_ST_SDA_LO:  enter_step = PH_ST_SCL_LO;
					PH_ST_SCL_LO:  enter_step = PH_BIT_SET;
					PH_BIT_SET:    enter_step = PH_BIT_SCL_HI;
					PH_BIT_SCL_HI: enter_step = PH_BIT_SCL_LO;
					PH_BIT_SCL_LO: enter_step = (cur.bits < BITS_PER_BYTE) ?
						PH_BIT_SET : PH_ACK_REL;
					PH_ACK_REL:    enter_step = PH_ACK_SCL_HI;
					PH_ACK_SCL_HI: enter_step = PH_ACK_SAMPLE;
					PH_ACK_SAMPLE: enter_step = PH_ACK_SCL_LO;
					PH_ACK_SCL_LO: enter_step = cur.stop ? PH_SP_SCL_LO : PH_IDLE;
					PH_SP_SCL_LO:  enter_step = PH_SP_SDA_LO;
					PH_SP_SDA_LO:  enter_step = PH_SP_SCL_HI;
					PH_SP_SCL_HI:  enter_step = PH_SP_SDA_HI;
					default:       enter_step = PH_IDLE;
				endcase
			end
		end
	end

	// pin action of the entered phase
	always_comb begin
		nxt = base;
		if (do_enter) begin
			nxt.step = enter_step;
			nxt.hold = hold_load;
			case (enter_step)
				PH_ST_SDA_HI:  nxt.sda = 1'b1;
				PH_ST_SCL_HI:  nxt.scl = 1'b1;
				PH_ST_SDA_LO:  nxt.sda = 1'b0;
				PH_ST_SCL_LO:  nxt.scl = 1'b0;
				PH_BIT_SET: begin
					nxt.sda   = ((base.shift & BYTE_MSB) != 8'h00);
					nxt.shift = {base.shift[6:0], 1'b0};
					nxt.bits  = base.bits + 4'd1;
				end
				PH_BIT_SCL_HI: nxt.scl = 1'b1;
				PH_BIT_SCL_LO: nxt.scl = 1'b0;
				PH_ACK_REL:    nxt.sda = 1'b1;
				PH_ACK_SCL_HI: nxt.scl = 1'b1;
				PH_ACK_SAMPLE: nxt.scl = base.scl;
				PH_ACK_SCL_LO: nxt.scl = 1'b0;
				PH_SP_SCL_LO:  nxt.scl = 1'b0;
				PH_SP_SDA_LO:  nxt.sda = 1'b0;
				PH_SP_SCL_HI:  nxt.scl = 1'b1;
				PH_SP_SDA_HI:  nxt.sda = 1'b1;
				default:       nxt.hold = '0;
			endcase
		end
	end

	// ack report, refusal and busy after this word
	always_comb begin
		flags.busy      = (nxt.step != PH_IDLE);
		flags.ack_valid = do_enter && (enter_step == PH_ACK_SAMPLE);
		flags.nack      = do_enter && (enter_step == PH_ACK_SAMPLE) && sda_in;
		flags.rejected  = reject;
	end

endmodule
`default_nettype wire

/* design/i2c_master_byte_writer_core.sv */
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// i2c_master_byte_writer_core
// Write-only i2c master: optional start, eight data bits, ack sample and optional
// stop, each pin phase held for a programmable number of tick words.
// ----------------------------------------------------------------------------
//  channel | handshake            | payload
//  --------+----------------------+-------------------------------------------
//  in      | in_valid / in_stall  | command data_byte frame_start frame_end
//          |                      | sda_in
//  out     | out_valid / out_stall| scl sda busy_res ack_valid nack rejected
//  cfg     | cfg_valid / cfg_ready| cfg_data (phase_ticks)
//
//  One word per cycle unless the output stalls; the result is in the output
//  register in the cycle after acceptance, set by the single next-state stage.
//  Reset: sequencer idle, both pin levels high (scl_q, sda_q not reset), phase_ticks = 2.
//  A stalled output register stalls the input; a word is taken in the same
//  cycle the waiting result leaves.
// ----------------------------------------------------------------------------
module i2c_master_byte_writer_core
	import i2cmbw_pkg::*;
(
	input  wire               clk,
	input  wire               arst_n,
	input  wire               in_valid,
	output logic              in_stall,
	input  wire               command,
	input  wire [7:0]         data_byte,
	input  wire               frame_start,
	input  wire               frame_end,
	input  wire               sda_in,
	output logic              out_valid,
	input  wire               out_stall,
	output logic              scl,
	output logic              sda,
	output logic              busy_res,
	output logic              ack_valid,
	output logic              nack,
	output logic              rejected,
	input  wire               cfg_valid,
	output logic              cfg_ready,
	input  wire [TICK_W-1:0]  cfg_data
);

	seq_state_t        state_q;
	seq_state_t        state_d;
	seq_flags_t        flags;
	seq_flags_t        flags_q;
	logic              scl_q;
	logic              sda_q;
	logic              out_valid_q;
	logic [TICK_W-1:0] phase_ticks_q;
	logic              in_take;

	// handshake
	assign cfg_ready = 1'b1;
	assign in_stall  = out_valid_q && out_stall;
	assign in_take   = in_valid && !in_stall;

	// configuration register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_ticks_q <= TICKS_RESET;
		end else if (cfg_valid && cfg_ready) begin
			phase_ticks_q <= cfg_data;
		end
	end

	// sequencer next state
	i2cmbw_step u_step (
		.cur         (state_q),
		.phase_ticks (phase_ticks_q),
		.command     (command),
		.data_byte   (data_byte),
		.frame_start (frame_start),
		.frame_end   (frame_end),
		.sda_in      (sda_in),
		.nxt         (state_d),
		.flags       (flags)
	);

	// sequencer state register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q.step  <= PH_IDLE;
			state_q.hold  <= '0;
			state_q.shift <= '0;
			state_q.bits  <= '0;
			state_q.stop  <= 1'b0;
			state_q.scl   <= 1'b1;
			state_q.sda   <= 1'b1;
		end else if (in_take) begin
			state_q <= state_d;
		end
	end

	// output word register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (in_take) begin
			out_valid_q <= 1'b1;
		end else if (!out_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (in_take) begin
			scl_q   <= state_d.scl;
			sda_q   <= state_d.sda;
			flags_q <= flags;
		end
	end

	assign out_valid = out_valid_q;
	assign scl       = scl_q;
	assign sda       = sda_q;
	assign busy_res  = flags_q.busy;
	assign ack_valid = flags_q.ack_valid;
	assign nack      = flags_q.nack;
	assign rejected  = flags_q.rejected;

endmodule
`default_nettype wire

/* design/i2cmbw_checker.sv */
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// i2cmbw_checker
// Port-level checks of the i2c byte master, bound to the top level.
// ----------------------------------------------------------------------------
module i2cmbw_checker (
	input wire               clk,
	input wire               arst_n,
	input wire               in_stall,
	input wire               out_valid,
	input wire               out_stall,
	input wire               scl,
	input wire               sda,
	input wire               busy_res,
	input wire               ack_valid,
	input wire               nack,
	input wire               rejected
);

	// ack is sampled in the middle of a sequence
	a_ack_busy: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && ack_valid |-> busy_res)
		else $error("ack reported while idle");

	// nack only together with a sampled ack
	a_nack_ack: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && nack |-> ack_valid)
		else $error("nack without ack_valid");

	// a dropped request leaves the sequence running
	a_rej_busy: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && rejected |-> busy_res && !ack_valid)
		else $error("rejected word while idle");

	// input stalls only behind a held result word
	a_stall_src: assert property (@(posedge clk) disable iff (!arst_n)
		in_stall |-> out_valid && out_stall)
		else $error("input stalled without a held result");

	// held result word keeps its pins
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_stall |=> out_valid && $stable(scl) && $stable(sda))
		else $error("stalled result word changed");

endmodule

bind i2c_master_byte_writer_core i2cmbw_checker u_i2cmbw_checker (.*);
`default_nettype wire

/* verif/i2c_byte_writer_line_checker.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// i2c_byte_writer_line_checker
// Watches the word, result and register channels of the i2c byte writer,
// runs its own copy of the pin sequencer on every accepted word and compares
// each result word against the oldest predicted line state.
// ----------------------------------------------------------------------------
module i2c_byte_writer_line_checker
	import i2cmbw_pkg::*;
(
	input  wire              clk,
	input  wire              arst_n,
	input  wire              in_valid,
	input  wire              in_stall,
	input  wire              command,
	input  wire [7:0]        data_byte,
	input  wire              frame_start,
	input  wire              frame_end,
	input  wire              sda_in,
	input  wire              out_valid,
	input  wire              out_stall,
	input  wire              scl,
	input  wire              sda,
	input  wire              busy_res,
	input  wire              ack_valid,
	input  wire              nack,
	input  wire              rejected,
	input  wire              cfg_valid,
	input  wire              cfg_ready,
	input  wire [TICK_W-1:0] cfg_data,
	output int unsigned      failures,
	output int unsigned      pending
);

	// pin levels and flags of one result word
	typedef struct packed {
		logic scl;
		logic sda;
		logic busy;
		logic ack_valid;
		logic nack;
		logic rejected;
	} line_word_t;

	line_word_t        line_queue[$];
	int unsigned       mismatch_cnt;

	// shadow sequencer
	phase_t            seq_phase;
	logic [TICK_W-1:0] hold_ticks;
	logic [TICK_W-1:0] hold_left;
	logic [7:0]        tx_shift;
	logic [3:0]        tx_bits;
	logic              stop_armed;
	logic              scl_drv;
	logic              sda_drv;

	// phase that follows once the hold of the current one runs out
	function automatic phase_t following_phase(phase_t ph);
		case (ph)
			PH_ST_SDA_HI:  return PH_ST_SCL_HI;
			PH_ST_SCL_HI:  return PH_ST_SDA_LO;
			PH_ST_SDA_LO:  return PH_ST_SCL_LO;
			PH_ST_SCL_LO:  return PH_BIT_SET;
			PH_BIT_SET:    return PH_BIT_SCL_HI;
			PH_BIT_SCL_HI: return PH_BIT_SCL_LO;
			PH_BIT_SCL_LO: return (tx_bits < BITS_PER_BYTE) ? PH_BIT_SET : PH_ACK_REL;
			PH_ACK_REL:    return PH_ACK_SCL_HI;
			PH_ACK_SCL_HI: return PH_ACK_SAMPLE;
			PH_ACK_SAMPLE: return PH_ACK_SCL_LO;
			PH_ACK_SCL_LO: return stop_armed ? PH_SP_SCL_LO : PH_IDLE;
			PH_SP_SCL_LO:  return PH_SP_SDA_LO;
			PH_SP_SDA_LO:  return PH_SP_SCL_HI;
			PH_SP_SCL_HI:  return PH_SP_SDA_HI;
			default:       return PH_IDLE;
		endcase
	endfunction

	// pin action on entry to a phase, hold reloaded (zero hold counts as one)
	task automatic enter_phase(phase_t ph);
		seq_phase = ph;
		hold_left = (hold_ticks == '0) ? TICK_W'(1) : hold_ticks;
		case (ph)
			PH_ST_SDA_HI, PH_ACK_REL, PH_SP_SDA_HI: sda_drv = 1'b1;
			PH_ST_SDA_LO, PH_SP_SDA_LO:             sda_drv = 1'b0;
			PH_ST_SCL_HI, PH_BIT_SCL_HI, PH_ACK_SCL_HI, PH_SP_SCL_HI: scl_drv = 1'b1;
			PH_ST_SCL_LO, PH_BIT_SCL_LO, PH_ACK_SCL_LO, PH_SP_SCL_LO: scl_drv = 1'b0;
			PH_BIT_SET: begin
				sda_drv  = ((tx_shift & BYTE_MSB) != '0);
				tx_shift = tx_shift << 1;
				tx_bits  = tx_bits + 4'd1;
			end
			default: begin
			end
		endcase
	endtask

	// expected result word for one accepted input word
	task automatic predict_line(input logic cmd, input logic [7:0] data, input logic fs,
			input logic fe, input logic sdi, output line_word_t res);
		phase_t nxt;
		res = '0;
		if (cmd_t'(cmd) == CMD_REQUEST) begin
			if (seq_phase != PH_IDLE) begin
				// request while busy is dropped and the sequence stands still
				res.rejected = 1'b1;
			end else begin
				tx_shift   = data;
				tx_bits    = '0;
				stop_armed = fe;
				enter_phase(fs ? PH_ST_SDA_HI : PH_BIT_SET);
			end
		end else if (seq_phase != PH_IDLE) begin
			if (hold_left != '0)
				hold_left = hold_left - 1'b1;
			if (hold_left == '0) begin
				nxt = following_phase(seq_phase);
				if (nxt == PH_IDLE) begin
					seq_phase = PH_IDLE;
					hold_left = '0;
				end else begin
					enter_phase(nxt);
					if (nxt == PH_ACK_SAMPLE) begin
						res.ack_valid = 1'b1;
						res.nack      = sdi;
					end
				end
			end
		end
		res.scl  = scl_drv;
		res.sda  = sda_drv;
		res.busy = (seq_phase != PH_IDLE);
	endtask

	task automatic check_field(input string name, input logic want, input logic got);
		if (want !== got) begin
			$error("%s: expected %0b, actual %0b", name, want, got);
			mismatch_cnt++;
		end
	endtask

	// compare leaving results first, then predict the arriving word
	always @(posedge clk or negedge arst_n) begin
		line_word_t want;
		line_word_t got;
		if (!arst_n) begin
			seq_phase    = PH_IDLE;
			hold_ticks   = TICKS_RESET;
			hold_left    = '0;
			tx_shift     = '0;
			tx_bits      = '0;
			stop_armed   = 1'b0;
			scl_drv      = 1'b1;
			sda_drv      = 1'b1;
			mismatch_cnt = 0;
			line_queue.delete();
		end else begin
			if (cfg_valid && cfg_ready)
				hold_ticks = cfg_data;
			if (out_valid && !out_stall) begin
				got = {scl, sda, busy_res, ack_valid, nack, rejected};
				if (line_queue.size() == 0) begin
					$error("result word arrived with nothing expected");
					mismatch_cnt++;
				end else begin
					want = line_queue.pop_front();
					check_field("scl", want.scl, got.scl);
					check_field("sda", want.sda, got.sda);
					check_field("busy_res", want.busy, got.busy);
					check_field("ack_valid", want.ack_valid, got.ack_valid);
					check_field("nack", want.nack, got.nack);
					check_field("rejected", want.rejected, got.rejected);
				end
			end
			if (in_valid && !in_stall) begin
				predict_line(command, data_byte, frame_start, frame_end, sda_in, want);
				line_queue.push_back(want);
			end
		end
		failures <= mismatch_cnt;
		pending  <= line_queue.size();
	end

endmodule

/* verif/tb_i2c_master_byte_writer_core.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_i2c_master_byte_writer_core
// Drives tick and byte request words into the i2c byte writer under random
// source gaps and sink stalls, sweeps the phase hold setting from zero to
// full scale, and reports the verdict from the line checker.
// ----------------------------------------------------------------------------
module tb_i2c_master_byte_writer_core;
	import i2cmbw_pkg::*;

	localparam int unsigned CYCLE_LIMIT  = 2_000_000;
	// random share of the run; drain ticks and directed words make up the rest
	localparam int unsigned RANDOM_WORDS = 400;
	localparam int unsigned HOLD_PHASES  = 5;
	localparam int unsigned PRESSURE_LEN = 400;

	// sink stall patterns
	typedef enum logic [1:0] {
		STALL_NONE,
		STALL_SPARSE,
		STALL_HEAVY,
		STALL_HOLD
	} stall_mode_t;

	logic              clk;
	logic              arst_n;
	logic              in_valid;
	logic              in_stall;
	logic              command;
	logic [7:0]        data_byte;
	logic              frame_start;
	logic              frame_end;
	logic              sda_in;
	logic              out_valid;
	logic              out_stall;
	logic              scl;
	logic              sda;
	logic              busy_res;
	logic              ack_valid;
	logic              nack;
	logic              rejected;
	logic              cfg_valid;
	logic              cfg_ready;
	logic [TICK_W-1:0] cfg_data;

	int unsigned failures;
	int unsigned pending;
	int unsigned words_sent;
	int unsigned active_ticks;
	logic        gapless;
	logic        pressure_go;

	i2c_master_byte_writer_core dut (
		.clk         (clk),
		.arst_n      (arst_n),
		.in_valid    (in_valid),
		.in_stall    (in_stall),
		.command     (command),
		.data_byte   (data_byte),
		.frame_start (frame_start),
		.frame_end   (frame_end),
		.sda_in      (sda_in),
		.out_valid   (out_valid),
		.out_stall   (out_stall),
		.scl         (scl),
		.sda         (sda),
		.busy_res    (busy_res),
		.ack_valid   (ack_valid),
		.nack        (nack),
		.rejected    (rejected),
		.cfg_valid   (cfg_valid),
		.cfg_ready   (cfg_ready),
		.cfg_data    (cfg_data)
	);

	i2c_byte_writer_line_checker line_chk (
		.clk         (clk),
		.arst_n      (arst_n),
		.in_valid    (in_valid),
		.in_stall    (in_stall),
		.command     (command),
		.data_byte   (data_byte),
		.frame_start (frame_start),
		.frame_end   (frame_end),
		.sda_in      (sda_in),
		.out_valid   (out_valid),
		.out_stall   (out_stall),
		.scl         (scl),
		.sda         (sda),
		.busy_res    (busy_res),
		.ack_valid   (ack_valid),
		.nack        (nack),
		.rejected    (rejected),
		.cfg_valid   (cfg_valid),
		.cfg_ready   (cfg_ready),
		.cfg_data    (cfg_data),
		.failures    (failures),
		.pending     (pending)
	);

	// clock
	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	// watchdog
	initial begin
		int unsigned cycles;
		cycles = 0;
		while (cycles < CYCLE_LIMIT) begin
			@(posedge clk);
			cycles++;
		end
		$display("tb_i2c_master_byte_writer_core: FAIL");
		$finish;
	end

	// sink stalls, with one long hold-off once random traffic begins
	initial begin
		stall_mode_t mode;
		int unsigned span;
		int unsigned r;
		logic        pressure_done;
		out_stall <= 1'b0;
		pressure_done = 1'b0;
		@(posedge arst_n);
		forever begin
			r = $urandom_range(0, 99);
			if (pressure_go && !pressure_done) begin
				mode = STALL_HOLD;
				span = PRESSURE_LEN;
				pressure_done = 1'b1;
			end else if (r < 30) begin
				mode = STALL_NONE;
				span = $urandom_range(5, 60);
			end else if (r < 70) begin
				mode = STALL_SPARSE;
				span = $urandom_range(5, 60);
			end else if (r < 97) begin
				mode = STALL_HEAVY;
				span = $urandom_range(5, 40);
			end else begin
				mode = STALL_HOLD;
				span = $urandom_range(20, 150);
			end
			repeat (span) begin
				@(posedge clk);
				case (mode)
					STALL_NONE:   out_stall <= 1'b0;
					STALL_SPARSE: out_stall <= ($urandom_range(0, 3) == 0);
					STALL_HEAVY:  out_stall <= 1'($urandom_range(0, 1));
					default:      out_stall <= 1'b1;
				endcase
			end
		end
	end

	// source gap after an accepted word, mostly short
	function automatic int unsigned pick_gap();
		int unsigned r;
		if (gapless)
			return 0;
		r = $urandom_range(0, 99);
		if (r < 55)
			return 0;
		if (r < 85)
			return $urandom_range(1, 3);
		if (r < 97)
			return $urandom_range(4, 12);
		return $urandom_range(20, 80);
	endfunction

	// offer one word, hold it until taken, then maybe idle
	task automatic send_word(input cmd_t cmd, input logic [7:0] b, input logic fs,
			input logic fe, input logic sdi);
		int unsigned gap;
		in_valid    <= 1'b1;
		command     <= cmd;
		data_byte   <= b;
		frame_start <= fs;
		frame_end   <= fe;
		sda_in      <= sdi;
		do
			@(posedge clk);
		while (in_stall);
		words_sent++;
		gap = pick_gap();
		if (gap != 0) begin
			in_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
	endtask

	task automatic send_tick_noise();
		send_word(CMD_TICK, 8'($urandom_range(0, 255)), 1'($urandom_range(0, 1)),
			1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)));
	endtask

	// one byte request followed by about enough ticks to finish it
	task automatic send_frame();
		logic        fs;
		logic        fe;
		int unsigned len;
		fs = 1'($urandom_range(0, 1));
		fe = 1'($urandom_range(0, 1));
		send_word(CMD_REQUEST, 8'($urandom_range(0, 255)), fs, fe,
			1'($urandom_range(0, 1)));
		len = ((fs ? 4 : 0) + 28 + (fe ? 4 : 0)) * active_ticks - 1 + $urandom_range(0, 4);
		repeat (len) begin
			if ($urandom_range(0, 11) == 0)
				send_word(CMD_REQUEST, 8'($urandom_range(0, 255)),
					1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)),
					1'($urandom_range(0, 1)));
			else
				send_tick_noise();
		end
	endtask

	// mostly whole frames, some bursts of arbitrary words
	task automatic run_random(input int unsigned target);
		while (words_sent < target) begin
			gapless = ($urandom_range(0, 3) == 0);
			if ($urandom_range(0, 9) == 0) begin
				repeat ($urandom_range(3, 15))
					send_word(cmd_t'(1'($urandom_range(0, 1))),
						8'($urandom_range(0, 255)), 1'($urandom_range(0, 1)),
						1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)));
			end else begin
				send_frame();
			end
		end
		gapless = 1'b0;
	endtask

	// wait until every result word has left
	task automatic settle();
		in_valid <= 1'b0;
		@(posedge clk);
		while (pending != 0)
			@(posedge clk);
		repeat (4) @(posedge clk);
	endtask

	// run the sequencer out to idle and let the results drain
	task automatic return_to_idle();
		repeat (37 * active_ticks + 2)
			send_tick_noise();
		settle();
	endtask

	task automatic write_phase_ticks(input logic [TICK_W-1:0] value);
		cfg_valid <= 1'b1;
		cfg_data  <= value;
		do
			@(posedge clk);
		while (!cfg_ready);
		cfg_valid    <= 1'b0;
		active_ticks = (value == '0) ? 1 : value;
	endtask

	// stimulus and verdict
	initial begin
		int unsigned hold_plan[HOLD_PHASES];
		in_valid    <= 1'b0;
		command     <= CMD_TICK;
		data_byte   <= '0;
		frame_start <= 1'b0;
		frame_end   <= 1'b0;
		sda_in      <= 1'b0;
		cfg_valid   <= 1'b0;
		cfg_data    <= '0;
		arst_n      <= 1'b0;
		gapless     = 1'b0;
		pressure_go = 1'b0;
		words_sent  = 0;
		active_ticks = 32'(TICKS_RESET);
		hold_plan   = '{1, 2, 1, 3, 4};
		hold_plan[HOLD_PHASES-1] = $urandom_range(1, 5);
		repeat (6) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// ticks while idle leave the pins alone
		send_word(CMD_TICK, 8'hFF, 1'b1, 1'b1, 1'b1);
		send_word(CMD_TICK, 8'h00, 1'b0, 1'b0, 1'b0);

		// start, byte, ack, stop at the reset hold; refused requests on the way
		send_word(CMD_REQUEST, 8'hA5, 1'b1, 1'b1, 1'b0);
		repeat (5) send_word(CMD_TICK, 8'h00, 1'b0, 1'b0, 1'b0);
		send_word(CMD_REQUEST, 8'h3C, 1'b1, 1'b0, 1'b1);
		repeat (66) send_word(CMD_TICK, 8'h00, 1'b0, 1'b0, 1'b0);
		send_word(CMD_REQUEST, 8'hC3, 1'b0, 1'b1, 1'b0);
		send_word(CMD_TICK, 8'h00, 1'b0, 1'b0, 1'b0);
		settle();

		// zero hold acts as one: bare byte with nack, then a framed byte with ack
		write_phase_ticks('0);
		send_word(CMD_REQUEST, 8'hFF, 1'b0, 1'b0, 1'b1);
		repeat (28) send_word(CMD_TICK, 8'h00, 1'b0, 1'b0, 1'b1);
		send_word(CMD_REQUEST, 8'h01, 1'b1, 1'b1, 1'b0);
		repeat (37) send_word(CMD_TICK, 8'h00, 1'b0, 1'b0, 1'b0);
		settle();

		// random traffic over a spread of hold settings
		pressure_go = 1'b1;
		for (int i = 0; i < HOLD_PHASES; i++) begin
			write_phase_ticks(TICK_W'(hold_plan[i]));
			run_random(words_sent + RANDOM_WORDS / HOLD_PHASES);
			return_to_idle();
		end

		// full-scale hold: one byte starts, a request meanwhile is refused
		write_phase_ticks({TICK_W{1'b1}});
		send_word(CMD_REQUEST, 8'($urandom_range(0, 255)), 1'b1, 1'b1,
			1'($urandom_range(0, 1)));
		repeat (30) send_tick_noise();
		send_word(CMD_REQUEST, 8'($urandom_range(0, 255)), 1'b0, 1'b0,
			1'($urandom_range(0, 1)));
		repeat (10) send_tick_noise();
		settle();

		if (failures == 0)
			$display("tb_i2c_master_byte_writer_core: PASS");
		else
			$display("tb_i2c_master_byte_writer_core: FAIL");
		$finish;
	end

endmodule
